### src/w3f_pkg.sv
// ----------------------------------------------------------------------------
// 3x3 window filter package
// Shared widths, mode codes and the pipeline depth of the quotient unit.
// ----------------------------------------------------------------------------
`default_nettype none
package w3f_pkg;
    localparam int PIX_W   = 8;
    localparam int NPIX    = 9;
    localparam int MODE_W  = 3;
    localparam int SQ_W    = 20;   // sum of nine squares < 2^20
    localparam int CU_W    = 28;   // sum of nine cubes < 2^28
    localparam int Q_W     = 8;    // quotient never exceeds the largest sample

    typedef enum logic [MODE_W-1:0] {
        MODE_GAUSS  = 3'd0,
        MODE_MEDIAN = 3'd1,
        MODE_SOBEL  = 3'd2,
        MODE_MEAN   = 3'd3,
        MODE_CHARM  = 3'd4
    } t_mode;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix t_win [NPIX];
endpackage
`default_nettype wire

### src/window3x3_multi_mode_filter.sv
// Results pass through the pre-processing stages, the quotient stages and the output register.
// Throughput: one item per cycle; the eight-stage quotient pipeline sets
// the depth, and a stall holds every stage in place.
// Reset (synchronous, active low) clears the valid bits and filter_mode to 0.
// ----------------------------------------------------------------------------
// 3x3 multi-mode window filter
// Gaussian, median, Sobel, mean and contraharmonic filters on one window.
// ----------------------------------------------------------------------------
`default_nettype none
module window3x3_multi_mode_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,     // filter_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pix_nw, pix_n, pix_ne, pix_w, pix_c, pix_e, pix_sw, pix_s, pix_se
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata     // pixel_out
);
    import w3f_pkg::*;

    localparam int DEPTH = 3 + Q_W;

    logic [MODE_W-1:0] r_mode;
    logic [DEPTH-1:0]  r_vld;
    logic [MODE_W-1:0] r_mq [2];
    logic              en;
    t_win              win;

    logic [7:0] g, md, sb, mn, side, quo, n_side;
    logic [CU_W-1:0] num;
    logic [SQ_W-1:0] den;
    logic [MODE_W-1:0] r_dmode [Q_W];
    logic [7:0] r_out;

    // The whole pipeline advances unless the output register is full and held.
    assign en = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int i = 0; i < NPIX; i++) win[i] = s_axis_tdata[8*i +: 8];
    end

    w3f_pre u_pre (
        .i_clk(i_clk), .i_en(en), .i_win(win),
        .o_gauss(g), .o_median(md), .o_sobel(sb), .o_mean(mn),
        .o_num(num), .o_den(den)
    );

    always_comb begin
        case (t_mode'(r_mq[1]))
            MODE_GAUSS:  n_side = g;
            MODE_MEDIAN: n_side = md;
            MODE_SOBEL:  n_side = sb;
            MODE_MEAN:   n_side = mn;
            default:     n_side = '0;
        endcase
    end

    w3f_div u_div (
        .i_clk(i_clk), .i_en(en), .i_num(num), .i_den(den),
        .i_side(n_side), .o_side(side), .o_quo(quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (en) r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
        if (en) begin
            r_mq[0] <= r_mode;
            r_mq[1] <= r_mq[0];
            r_dmode[0] <= r_mq[1];
            for (int k = 1; k < Q_W; k++) r_dmode[k] <= r_dmode[k-1];
            r_out <= (t_mode'(r_dmode[Q_W-1]) == MODE_CHARM) ? quo : side;
        end
    end

    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire

### src/w3f_pre.sv
// ----------------------------------------------------------------------------
// 3x3 window filter, first stages
// Computes the linear sums, the median sorting network and the power sums.
// Two register stages, each gated by the shared advance signal.
// ----------------------------------------------------------------------------
`default_nettype none
module w3f_pre (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire w3f_pkg::t_win           i_win,
    output logic [w3f_pkg::PIX_W-1:0]    o_gauss,
    output logic [w3f_pkg::PIX_W-1:0]    o_median,
    output logic [w3f_pkg::PIX_W-1:0]    o_sobel,
    output logic [w3f_pkg::PIX_W-1:0]    o_mean,
    output logic [w3f_pkg::CU_W-1:0]     o_num,
    output logic [w3f_pkg::SQ_W-1:0]     o_den
);
    import w3f_pkg::*;

    // Stage A: squares, weighted and plain sums, sobel components, first sort layer.
    logic [15:0] r_sq [NPIX];
    logic [7:0]  r_pix [NPIX];
    logic [11:0] r_gsum;
    logic [11:0] r_sum;
    logic [10:0] r_gx_abs, r_gy_abs;
    t_pix        r_sort [NPIX];

    logic signed [11:0] n_gx, n_gy;
    logic [11:0] n_gsum, n_sum;
    t_pix        n_sort [NPIX];

    function automatic void cs(inout t_pix a, inout t_pix b);
        t_pix t;
        if (a > b) begin
            t = a; a = b; b = t;
        end
    endfunction

    always_comb begin
        n_gsum = 12'(i_win[0]) + 12'({i_win[1], 1'b0}) + 12'(i_win[2])
               + 12'({i_win[3], 1'b0}) + 12'({i_win[4], 2'b0}) + 12'({i_win[5], 1'b0})
               + 12'(i_win[6]) + 12'({i_win[7], 1'b0}) + 12'(i_win[8]);
        n_sum = '0;
        for (int i = 0; i < NPIX; i++) n_sum = n_sum + 12'(i_win[i]);
        n_gx = -12'sd0 - $signed(12'(i_win[0])) + $signed(12'(i_win[2]))
             - $signed(12'({i_win[3], 1'b0})) + $signed(12'({i_win[5], 1'b0}))
             - $signed(12'(i_win[6])) + $signed(12'(i_win[8]));
        n_gy = -12'sd0 - $signed(12'(i_win[0])) - $signed(12'({i_win[1], 1'b0}))
             - $signed(12'(i_win[2])) + $signed(12'(i_win[6]))
             + $signed(12'({i_win[7], 1'b0})) + $signed(12'(i_win[8]));
        for (int i = 0; i < NPIX; i++) n_sort[i] = i_win[i];
        // Sort each row of three.
        for (int r = 0; r < 3; r++) begin
            cs(n_sort[3*r], n_sort[3*r+1]);
            cs(n_sort[3*r+1], n_sort[3*r+2]);
            cs(n_sort[3*r], n_sort[3*r+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NPIX; i++) begin
                r_sq[i]   <= 16'(i_win[i]) * 16'(i_win[i]);
                r_pix[i]  <= i_win[i];
                r_sort[i] <= n_sort[i];
            end
            r_gsum   <= n_gsum;
            r_sum    <= n_sum;
            r_gx_abs <= 11'(n_gx < 0 ? -n_gx : n_gx);
            r_gy_abs <= 11'(n_gy < 0 ? -n_gy : n_gy);
        end
    end

    // Stage B: cubes and power sums, median finish, mean by reciprocal.
    logic [CU_W-1:0] n_num;
    logic [SQ_W-1:0] n_den;
    logic [11:0]     n_mag;
    t_pix            n_lo, n_md, n_hi, n_a, n_b, n_c;
    logic [23:0]     n_mprod;

    always_comb begin
        n_num = '0;
        n_den = '0;
        for (int i = 0; i < NPIX; i++) begin
            n_num = n_num + CU_W'(24'(r_sq[i]) * 24'(r_pix[i]));
            n_den = n_den + SQ_W'(r_sq[i]);
        end
        n_mag = 12'(r_gx_abs) + 12'(r_gy_abs);
        // Median of nine from sorted rows: max of mins, median of medians,
        // min of maxes, then the median of those three.
        n_lo = r_sort[0];
        if (r_sort[3] > n_lo) n_lo = r_sort[3];
        if (r_sort[6] > n_lo) n_lo = r_sort[6];
        n_hi = r_sort[2];
        if (r_sort[5] < n_hi) n_hi = r_sort[5];
        if (r_sort[8] < n_hi) n_hi = r_sort[8];
        n_a = r_sort[1]; n_b = r_sort[4]; n_c = r_sort[7];
        cs(n_a, n_b); cs(n_b, n_c); cs(n_a, n_b);
        n_md = n_b;
        n_a = n_lo; n_b = n_md; n_c = n_hi;
        cs(n_a, n_b); cs(n_b, n_c); cs(n_a, n_b);
        // sum / 9 for sum < 2296: (sum * 3641) >> 15 is exact in this range.
        n_mprod = 24'(r_sum) * 24'd3641;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num    <= n_num;
            o_den    <= n_den;
            o_gauss  <= r_gsum[11:4];
            o_median <= n_b;
            o_sobel  <= (n_mag > 12'd255) ? 8'hff : n_mag[7:0];
            o_mean   <= n_mprod[22:15];
        end
    end
endmodule
`default_nettype wire

### src/w3f_div.sv
// ----------------------------------------------------------------------------
// 3x3 window filter quotient unit
// Pipelined restoring divider, one quotient bit per stage, 8 stages.
// ----------------------------------------------------------------------------
`default_nettype none
module w3f_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [w3f_pkg::CU_W-1:0] i_num,
    input  wire logic [w3f_pkg::SQ_W-1:0] i_den,
    input  wire logic [7:0]              i_side,   // result of the other modes
    output logic [7:0]                   o_side,
    output logic [w3f_pkg::Q_W-1:0]      o_quo
);
    import w3f_pkg::*;

    logic [CU_W-1:0] r_rem  [Q_W];
    logic [SQ_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]  r_quo  [Q_W];
    logic [7:0]      r_side [Q_W];

    // Stage k tests quotient bit Q_W-1-k: compare rem with den << bit.
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [CU_W-1:0]     n_rem;
        logic [SQ_W-1:0]     n_den;
        logic [Q_W-1:0]      n_quo;
        logic [7:0]          n_sd;
        logic [CU_W+Q_W-1:0] n_sh;
        logic                n_ge;
        if (k == 0) begin : g_first
            assign n_rem = i_num;
            assign n_den = i_den;
            assign n_quo = '0;
            assign n_sd  = i_side;
        end else begin : g_next
            assign n_rem = r_rem[k-1];
            assign n_den = r_den[k-1];
            assign n_quo = r_quo[k-1];
            assign n_sd  = r_side[k-1];
        end
        assign n_sh = (CU_W+Q_W)'(n_den) << B;
        assign n_ge = (n_den != '0) && ((CU_W+Q_W)'(n_rem) >= n_sh);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? CU_W'((CU_W+Q_W)'(n_rem) - n_sh) : n_rem;
                r_den[k]  <= n_den;
                r_quo[k]  <= n_quo | (n_ge ? Q_W'(1) << B : '0);
                r_side[k] <= n_sd;
            end
        end
    end

    assign o_quo  = r_quo[Q_W-1];
    assign o_side = r_side[Q_W-1];
endmodule
`default_nettype wire

### src/w3f_checker.sv
// ----------------------------------------------------------------------------
// 3x3 window filter port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none
module w3f_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

bind window3x3_multi_mode_filter w3f_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### tb/tb_window3x3_multi_mode_filter.sv
// ----------------------------------------------------------------------------
// Testbench for the 3x3 multi-mode window filter
// Streams windows through every filter mode with random gaps on both sides
// and compares each output pixel against a behavioral prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_window3x3_multi_mode_filter;
    import w3f_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 11;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        logic [71:0] win;
        logic        cfg;        // item is a mode change marker
        logic [2:0]  mode;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    window3x3_multi_mode_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item       pending_items[$];
    logic [7:0]  expected_pixels[$];
    logic [2:0]  tb_mode = 3'd0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          drain_wait = 0;
    int          next_gap = 0;
    bit          stim_done = 1'b0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] filter_pixel(logic [2:0] mode, logic [71:0] win);
        int v[9];
        int t, s, gx, gy, m;
        longint num, den;
        for (int i = 0; i < 9; i++) v[i] = win[i*8 +: 8];
        case (mode)
            MODE_GAUSS: begin
                s = v[0] + 2*v[1] + v[2] + 2*v[3] + 4*v[4] + 2*v[5] + v[6] + 2*v[7] + v[8];
                return 8'(s >> 4);
            end
            MODE_MEDIAN: begin
                for (int i = 1; i < 9; i++)
                    for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
                        t = v[j]; v[j] = v[j-1]; v[j-1] = t;
                    end
                return 8'(v[4]);
            end
            MODE_SOBEL: begin
                gx = -v[0] + v[2] - 2*v[3] + 2*v[5] - v[6] + v[8];
                gy = -v[0] - 2*v[1] - v[2] + v[6] + 2*v[7] + v[8];
                m = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                return m > 255 ? 8'hff : m[7:0];
            end
            MODE_MEAN: begin
                s = 0;
                for (int i = 0; i < 9; i++) s += v[i];
                return 8'(s / 9);
            end
            MODE_CHARM: begin
                num = 0; den = 0;
                for (int i = 0; i < 9; i++) begin
                    den += longint'(v[i]) * v[i];
                    num += longint'(v[i]) * v[i] * v[i];
                end
                if (den == 0) return 8'd0;
                num = num / den;
                return num > 255 ? 8'hff : num[7:0];
            end
            default: return 8'd0;
        endcase
    endfunction

    task automatic report_mismatch(logic [7:0] got, logic [7:0] want);
        $display("mismatch at cycle %0d: pixel_out %0d, expected %0d",
                 cycle_count, got, want);
        error_count++;
    endtask

    task automatic add_window(logic [71:0] w);
        t_item it;
        it.win = w; it.cfg = 1'b0; it.mode = '0;
        pending_items.push_back(it);
    endtask

    task automatic add_mode(logic [2:0] m);
        t_item it;
        it.win = '0; it.cfg = 1'b1; it.mode = m;
        pending_items.push_back(it);
    endtask

    function automatic logic [71:0] rand_window();
        logic [71:0] w;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0: w[i*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                1: w[i*8 +: 8] = 8'($urandom_range(0, 3));
                2: w[i*8 +: 8] = 8'($urandom_range(240, 255));
                default: w[i*8 +: 8] = 8'($urandom);
            endcase
        end
        return w;
    endfunction

    // Driver: a mode marker waits until the pipeline is empty and quiet.
    // With no gap drawn, the next window follows in the very next cycle.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_cfg_we <= 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pixels.push_back(filter_pixel(tb_mode, s_axis_tdata));
                void'(pending_items.pop_front());
                next_gap = rand_gap();
                if (next_gap == 0 && pending_items.size() > 0 && !pending_items[0].cfg) begin
                    s_axis_tdata <= pending_items[0].win;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    in_gap <= next_gap;
                end
            end else if (!s_axis_tvalid && pending_items.size() > 0) begin
                if (pending_items[0].cfg) begin
                    if (expected_pixels.size() == 0 && drain_wait >= LATENCY + 2) begin
                        i_cfg_we <= 1'b1;
                        i_cfg_wdata <= pending_items[0].mode;
                        tb_mode <= pending_items[0].mode;
                        void'(pending_items.pop_front());
                        drain_wait <= 0;
                    end else begin
                        drain_wait <= expected_pixels.size() == 0 ? drain_wait + 1 : 0;
                    end
                end else if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_items[0].win;
                end
            end
        end
    end

    // Monitor with a randomly stalling receiver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("unexpected item at cycle %0d: pixel_out %0d",
                             cycle_count, m_axis_tdata);
                    error_count++;
                end else begin
                    if (m_axis_tdata !== expected_pixels[0])
                        report_mismatch(m_axis_tdata, expected_pixels[0]);
                    void'(expected_pixels.pop_front());
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap <= rand_gap();
            end
        end
    end

    initial begin
        logic [71:0] w;
        logic [2:0] modes[8];
        // Directed part: extremes and special windows in each mode.
        modes = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd6};
        foreach (modes[k]) begin
            add_mode(modes[k]);
            add_window('0);
            add_window({72{1'b1}});
            add_window(72'h00_ff_ff_00_00_00_00_ff_ff);
        end
        add_mode(MODE_SOBEL);
        add_window(72'hff_ff_ff_00_00_00_00_00_00);
        add_window(72'hff_00_00_ff_00_00_ff_00_00);
        add_mode(MODE_CHARM);
        add_window(72'h00_00_00_00_01_00_00_00_00);
        // Random part in phases with varied modes, extremes included.
        for (int p = 0; p < 26; p++) begin
            if (p == 0) add_mode(MODE_GAUSS);
            else if (p == 1) add_mode(3'd7);
            else add_mode(3'($urandom_range(0, 7) < 7 ? $urandom_range(0, 4) : 5));
            for (int n = 0; n < 75; n++) begin
                w = rand_window();
                add_window(w);
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_pixels.size() == 0);
        repeat (LATENCY * 3) @(posedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done || cycle_count >= CYCLE_CAP);
        if (!stim_done) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end else begin
            if (error_count == 0 && expected_pixels.size() == 0) begin
                $display("DONE: 0 errors");
            end else begin
                if (expected_pixels.size() != 0)
                    $display("%0d results never arrived", expected_pixels.size());
                $display("DONE: errors detected");
            end
            $finish;
        end
    end
endmodule
`default_nettype wire

### filelist.f
src/w3f_pkg.sv
src/w3f_pre.sv
src/w3f_div.sv
src/window3x3_multi_mode_filter.sv
src/w3f_checker.sv
tb/tb_window3x3_multi_mode_filter.sv
